@@ hdl/iup_pkg.sv @@
// ----------------------------------------------------------------------------
// iup_pkg: shared types and constants for the utilization profile
// Action codes, register indexes, sequencer states and saturating Q16.16 helpers.
// ----------------------------------------------------------------------------
package iup_pkg;

    localparam int unsigned DEF_MAX_POINTS = 64;

    localparam logic REG_ENABLE   = 1'b0;
    localparam logic REG_NOW_UTIL = 1'b1;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_MAX   = 2'd1,
        ACT_BELOW = 2'd2,
        ACT_FINAL = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_QUERY_RD,
        ST_QUERY,
        ST_OUT
    } state_t;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_add = s[31:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) begin
            sat_sub = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sat_sub = s[31:0];
        end
    endfunction

endpackage

@@ hdl/interval_utilization_profile.sv @@
// ----------------------------------------------------------------------------
// interval_utilization_profile: step profile of resource reservations
// Sorted breakpoint table in two memories, walked one entry per beat step.
// ----------------------------------------------------------------------------
//  channel  | ports                         | payload
//  s_       | s_tvalid s_tready s_tdata     | action,start,duration,amount,thr
//  m_       | m_tvalid m_tready m_tdata     | level,below_time,found,table_full
//  cfg      | cfg_we cfg_index cfg_wdata    | reservations_enabled, now_util
//
// An add runs a hit scan, a rebuild pass into a scratch memory and a
// copy-back pass that drops equal neighbours, each pass with a read state
// and a second state per entry. Queries walk the table the same way; the
// final amount takes a single read. Reset empties the profile at once; no
// clearing pass. s_tready is low from acceptance until the result beat is
// taken.
module interval_utilization_profile #(
    parameter int unsigned MAX_POINTS = iup_pkg::DEF_MAX_POINTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], start[33:2], duration[65:34], amount[97:66],
    // threshold[129:98], zero fill to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // level[31:0], below_time[63:32], found[64], table_full[65], zero fill
    output logic [71:0]  m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata
);
    import iup_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned CW = $clog2(MAX_POINTS + 1);

    logic [31:0] p_time_mem [MAX_POINTS];
    logic [31:0] p_amt_mem  [MAX_POINTS];
    logic [31:0] t_time_mem [MAX_POINTS];
    logic [31:0] t_amt_mem  [MAX_POINTS];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next, idx_reg, idx_next, tn_reg, tn_next;
    logic en_reg;
    logic signed [31:0] now_reg;
    action_t act_reg;
    logic [31:0] st_reg, et_reg, dur_reg;
    logic signed [31:0] amt_reg, thr_reg;
    logic hit_s_reg, hit_s_next, hit_e_reg, hit_e_next;
    logic sdone_reg, sdone_next, edone_reg, edone_next;
    logic signed [31:0] last_reg, last_next;
    logic signed [31:0] level_reg, level_next, prev_reg, prev_next;
    logic [31:0] below_reg, below_next;
    logic found_reg, found_next, full_reg, full_next, begun_reg, begun_next;
    logic [31:0] rd_time;
    logic signed [31:0] rd_amt;
    logic [31:0] tr_time, tr_amt;
    logic [AW-1:0] rd_addr;
    logic          p_we, t_we;
    logic [AW-1:0] p_waddr, t_waddr;
    logic [31:0]   p_wtime, p_wamt, t_wtime, t_wamt;
    logic          push_v;
    logic [31:0]   push_t;
    logic signed [31:0] push_a;
    logic [32:0]   et_sum;
    logic [CW:0]   need;
    logic          need_over;
    logic          add_skip;
    logic          q_done;

    // ---- memories ----
    always_ff @(posedge aclk) begin
        if (p_we) begin
            p_time_mem[p_waddr] <= p_wtime;
            p_amt_mem[p_waddr]  <= p_wamt;
        end
        if (t_we) begin
            t_time_mem[t_waddr] <= t_wtime;
            t_amt_mem[t_waddr]  <= t_wamt;
        end
        rd_time <= p_time_mem[rd_addr];
        rd_amt  <= p_amt_mem[rd_addr];
        tr_time <= t_time_mem[rd_addr];
        tr_amt  <= t_amt_mem[rd_addr];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {6'd0, full_reg, found_reg, below_reg, level_reg};
    assign et_sum    = {1'b0, s_tdata[33:2]} + {1'b0, s_tdata[65:34]};
    assign need      = {1'b0, count_reg} + (CW+1)'(!hit_s_reg) + (CW+1)'(!hit_e_reg);
    assign need_over = (need > (CW+1)'(MAX_POINTS));
    assign add_skip  = !en_reg || (dur_reg == '0) || (et_reg == st_reg);

    // ---- registers ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            en_reg    <= 1'b1;
            now_reg   <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we) begin
                if (cfg_index == REG_NOW_UTIL) now_reg <= cfg_wdata;
                else                           en_reg  <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            act_reg <= action_t'(s_tdata[1:0]);
            st_reg  <= s_tdata[33:2];
            dur_reg <= s_tdata[65:34];
            et_reg  <= et_sum[32] ? 32'hFFFF_FFFF : et_sum[31:0];
            amt_reg <= s_tdata[97:66];
            thr_reg <= s_tdata[129:98];
        end
        idx_reg   <= idx_next;
        tn_reg    <= tn_next;
        hit_s_reg <= hit_s_next;
        hit_e_reg <= hit_e_next;
        sdone_reg <= sdone_next;
        edone_reg <= edone_next;
        last_reg  <= last_next;
        level_reg <= level_next;
        prev_reg  <= prev_next;
        below_reg <= below_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        begun_reg <= begun_next;
    end

    // ---- next state ----
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[1:0] == ACT_ADD) state_next = ST_SCAN_RD;
                    else                         state_next = ST_QUERY_RD;
                end
            end
            ST_SCAN_RD: begin
                if (add_skip) state_next = ST_OUT;
                else if (idx_reg == count_reg) state_next = need_over ? ST_OUT : ST_COPY_RD;
                else state_next = ST_SCAN;
            end
            ST_SCAN:     state_next = ST_SCAN_RD;
            ST_COPY_RD:  state_next = ST_COPY_WR;
            ST_COPY_WR: begin
                if (idx_reg == count_reg) begin
                    state_next = (sdone_reg && edone_reg) ? ST_MERGE_RD : ST_COPY_WR;
                end else begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_MERGE_RD: state_next = (idx_reg == tn_reg) ? ST_OUT : ST_MERGE_WR;
            ST_MERGE_WR: state_next = ST_MERGE_RD;
            ST_QUERY_RD: state_next = ST_QUERY;
            ST_QUERY:    state_next = q_done ? ST_OUT : ST_QUERY_RD;
            ST_OUT: if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // ---- datapath ----
    always_comb begin
        idx_next   = idx_reg;
        tn_next    = tn_reg;
        count_next = count_reg;
        hit_s_next = hit_s_reg;
        hit_e_next = hit_e_reg;
        sdone_next = sdone_reg;
        edone_next = edone_reg;
        last_next  = last_reg;
        level_next = level_reg;
        prev_next  = prev_reg;
        below_next = below_reg;
        found_next = found_reg;
        full_next  = full_reg;
        begun_next = begun_reg;
        q_done     = 1'b0;
        rd_addr    = idx_reg[AW-1:0];
        p_we = 1'b0; t_we = 1'b0;
        p_waddr = tn_reg[AW-1:0]; t_waddr = tn_reg[AW-1:0];
        p_wtime = tr_time; p_wamt = tr_amt;
        t_wtime = '0; t_wamt = '0;
        push_v = 1'b0; push_t = '0; push_a = '0;
        case (state_reg)
            ST_IDLE: begin
                idx_next = '0; tn_next = '0;
                hit_s_next = 1'b0; hit_e_next = 1'b0;
                sdone_next = 1'b0; edone_next = 1'b0;
                last_next = '0; level_next = '0; below_next = '0; prev_next = '0;
                found_next = 1'b0; full_next = 1'b0; begun_next = 1'b0;
                if (s_tdata[1:0] != ACT_ADD && s_tdata[1:0] != ACT_MAX)
                    idx_next = count_reg;
            end
            ST_SCAN_RD: begin
                if (!add_skip && idx_reg == count_reg) begin
                    if (need_over) full_next = 1'b1;
                    idx_next = '0;
                    tn_next  = '0;
                end
            end
            ST_SCAN: begin
                if (rd_time == st_reg) hit_s_next = 1'b1;
                if (rd_time == et_reg) hit_e_next = 1'b1;
                idx_next = idx_reg + CW'(1);
            end
            ST_COPY_WR: begin
                // at most one push per visit; breakpoints that spawn a new point stall idx
                if (idx_reg != count_reg) begin
                    if (!sdone_reg && rd_time >= st_reg) begin
                        sdone_next = 1'b1;
                        if (rd_time == st_reg) begin
                            push_v = 1'b1; push_t = rd_time;
                            push_a = sat_add(rd_amt, amt_reg);
                            idx_next = idx_reg + CW'(1);
                        end else begin
                            push_v = 1'b1; push_t = st_reg;
                            push_a = sat_add(last_reg, amt_reg);
                        end
                    end else if (sdone_reg && !edone_reg && rd_time < et_reg) begin
                        push_v = 1'b1; push_t = rd_time;
                        push_a = sat_add(rd_amt, amt_reg);
                        idx_next = idx_reg + CW'(1);
                    end else if (sdone_reg && !edone_reg) begin
                        edone_next = 1'b1;
                        if (rd_time == et_reg) begin
                            push_v = 1'b1; push_t = rd_time; push_a = rd_amt;
                            idx_next = idx_reg + CW'(1);
                        end else begin
                            push_v = 1'b1; push_t = et_reg;
                            push_a = sat_sub(last_reg, amt_reg);
                        end
                    end else begin
                        push_v = 1'b1; push_t = rd_time; push_a = rd_amt;
                        idx_next = idx_reg + CW'(1);
                    end
                end else if (!sdone_reg) begin
                    sdone_next = 1'b1;
                    push_v = 1'b1; push_t = st_reg; push_a = sat_add(last_reg, amt_reg);
                end else if (!edone_reg) begin
                    edone_next = 1'b1;
                    push_v = 1'b1; push_t = et_reg; push_a = sat_sub(last_reg, amt_reg);
                end else begin
                    idx_next = '0;
                    count_next = '0;
                end
                if (push_v) begin
                    t_we = 1'b1; t_wtime = push_t; t_wamt = push_a;
                    tn_next = tn_reg + CW'(1);
                    last_next = push_a;
                end
            end
            ST_MERGE_WR: begin
                // drop an entry whose amount equals the one kept before it
                if (count_reg == '0 || tr_amt != prev_reg) begin
                    p_we = 1'b1; p_waddr = count_reg[AW-1:0];
                    p_wtime = tr_time; p_wamt = tr_amt;
                    count_next = count_reg + CW'(1);
                    prev_next = tr_amt;
                end
                idx_next = idx_reg + CW'(1);
            end
            ST_QUERY_RD: begin
                rd_addr = (act_reg == ACT_MAX) ? idx_reg[AW-1:0]
                                               : AW'(idx_reg - CW'(1));
            end
            ST_QUERY: begin
                case (act_reg)
                    ACT_MAX: begin
                        if (st_reg == '0) begin
                            level_next = now_reg;
                            q_done = 1'b1;
                        end else if (idx_reg == count_reg) begin
                            q_done = 1'b1;
                        end else if (rd_time <= st_reg) begin
                            level_next = rd_amt;
                            idx_next = idx_reg + CW'(1);
                        end else if (rd_time < et_reg) begin
                            if (rd_amt > level_reg) level_next = rd_amt;
                            idx_next = idx_reg + CW'(1);
                        end else begin
                            q_done = 1'b1;
                        end
                    end
                    ACT_BELOW: begin
                        // walk down from the last entry
                        if (idx_reg == '0) begin
                            below_next = '0;
                            q_done = 1'b1;
                        end else if (begun_reg && rd_amt > thr_reg && prev_reg <= thr_reg) begin
                            found_next = 1'b1;
                            q_done = 1'b1;
                        end else begin
                            prev_next = rd_amt;
                            below_next = rd_time;
                            begun_next = 1'b1;
                            idx_next = idx_reg - CW'(1);
                        end
                    end
                    default: begin
                        if (idx_reg != '0) level_next = rd_amt;
                        q_done = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // ---- checks ----
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_POINTS)) else $error("count overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("accepted while busy");
    a_full_add: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && full_reg |-> act_reg == ACT_ADD) else $error("full on query");

endmodule
